[sv/ffba_pkg.sv]
`default_nettype none
package ffba_pkg;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_ZERO    = 3'd1;
   localparam logic [2:0] ST_HEAP    = 3'd2;
   localparam logic [2:0] ST_TABLE   = 3'd3;
   localparam logic [2:0] ST_BADFREE = 3'd4;

   // request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // configuration register indexes (byte address bit 2)
   localparam logic REG_HEAP_LIMIT   = 1'b0;
   localparam logic REG_HEADER_BYTES = 1'b1;

   // fixed field widths
   localparam int SIZE_W   = 24;
   localparam int INDEX_W  = 6;
   localparam int LIMIT_W  = 25;
   localparam int HEADER_W = 7;
   localparam int SUM_W    = 26;

   localparam logic [LIMIT_W-1:0]  HEAP_LIMIT_RESET   = 25'd16777216;
   localparam logic [HEADER_W-1:0] HEADER_BYTES_RESET = 7'd24;

   localparam int MAX_BLOCKS_DEFAULT = 64;
   localparam int ADDR_BITS_DEFAULT  = 24;

endpackage
`default_nettype wire

[sv/first_fit_block_allocator_unit.sv]
// channel   handshake                 payload
// req       req_valid / req_stall     req_op, req_alloc_size, req_block_index
// rsp       rsp_valid / rsp_stall     rsp_status, rsp_payload_address,
//                                     rsp_granted_index, rsp_reused
// csr       psel penable pwrite pready paddr, pwdata, prdata
//
// One request at a time. A free reads the indexed entry and checks it before
// its result, or goes straight to the result when the index is past the table;
// an allocate scans the table entries (up to MAX_BLOCKS, 0 for a zero size),
// one entry per cycle through the single-port read of the block table memory,
// and tries to append a new entry when no free entry fits.
// Reset (synchronous) empties the table and sets heap top to zero; no
// clearing pass is needed since only entries below the count are read.
// A finished result waits in the output register while the next request
// is taken; a stalled result holds the block only when a second one is ready.
`default_nettype none
module first_fit_block_allocator_unit #(
   parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEFAULT,
   parameter int ADDR_BITS  = ffba_pkg::ADDR_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_op,
   input  wire logic [ffba_pkg::SIZE_W-1:0]   req_alloc_size,
   input  wire logic [ffba_pkg::INDEX_W-1:0]  req_block_index,

   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [2:0]                         rsp_status,
   output logic [ffba_pkg::SIZE_W-1:0]        rsp_payload_address,
   output logic [ffba_pkg::INDEX_W-1:0]       rsp_granted_index,
   output logic                               rsp_reused,

   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [2:0]                    paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   localparam int SIZE_W = ffba_pkg::SIZE_W;
   localparam int SUM_W  = ffba_pkg::SUM_W;
   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int TOP_W  = (ADDR_BITS >= 25) ? 25 : ADDR_BITS + 1;
   localparam int WORD_W = SIZE_W + TOP_W + 1;
   localparam logic [SUM_W-1:0] ADDR_SPAN =
      (ADDR_BITS >= 25) ? 26'd33554432 : (26'd1 << ADDR_BITS);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_FREE_CHK = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_APPEND   = 3'd3;
   localparam logic [2:0] S_RESULT   = 3'd4;

   // configuration registers
   logic [ffba_pkg::LIMIT_W-1:0]  heap_limit_ff;
   logic [ffba_pkg::HEADER_W-1:0] header_bytes_ff;
   logic                          cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_limit_ff   <= ffba_pkg::HEAP_LIMIT_RESET;
         header_bytes_ff <= ffba_pkg::HEADER_BYTES_RESET;
      end else if (cfg_write) begin
         unique case (paddr[2])
            ffba_pkg::REG_HEAP_LIMIT:   heap_limit_ff   <= pwdata[ffba_pkg::LIMIT_W-1:0];
            ffba_pkg::REG_HEADER_BYTES: header_bytes_ff <= pwdata[ffba_pkg::HEADER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         ffba_pkg::REG_HEAP_LIMIT:   prdata = 32'(heap_limit_ff);
         ffba_pkg::REG_HEADER_BYTES: prdata = 32'(header_bytes_ff);
         default:                    prdata = '0;
      endcase
   end

   // block table memory: {size, start, free}
   logic [WORD_W-1:0] entry_mem_ff [MAX_BLOCKS];
   logic [WORD_W-1:0] mem_rdata_ff;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_raddr;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [WORD_W-1:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= entry_mem_ff[mem_raddr];
      end
   end

   logic              rd_free;
   logic [TOP_W-1:0]  rd_start;
   logic [SIZE_W-1:0] rd_size;

   assign rd_free  = mem_rdata_ff[0];
   assign rd_start = mem_rdata_ff[TOP_W:1];
   assign rd_size  = mem_rdata_ff[WORD_W-1:TOP_W+1];

   // control and request state
   logic [2:0]                     state_ff, state_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [TOP_W-1:0]               heap_top_ff, heap_top_in;
   logic [IDX_W-1:0]               ptr_ff, ptr_in;
   logic [SIZE_W-1:0]              size_ff, size_in;
   logic [ffba_pkg::INDEX_W-1:0]   index_ff, index_in;
   logic [SUM_W-1:0]               base_ff, base_in;
   logic [SUM_W-1:0]               limit_ff, limit_in;

   logic [2:0]                     res_status_ff, res_status_in;
   logic [SIZE_W-1:0]              res_addr_ff, res_addr_in;
   logic [ffba_pkg::INDEX_W-1:0]   res_index_ff, res_index_in;
   logic                           res_reused_ff, res_reused_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [2:0]                     rsp_status_ff, rsp_status_in;
   logic [SIZE_W-1:0]              rsp_addr_ff, rsp_addr_in;
   logic [ffba_pkg::INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                           rsp_reused_ff, rsp_reused_in;

   logic                           req_take;
   logic                           free_in_range;
   logic                           scan_hit;
   logic                           scan_last;
   logic [SUM_W-1:0]               new_top;
   logic [SUM_W-1:0]               limit_cap;
   logic                           rsp_load;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid & ~req_stall;

   assign free_in_range = (32'(req_block_index) < 32'(count_ff)) &&
                          (32'(req_block_index) < 32'(MAX_BLOCKS));
   assign scan_hit  = rd_free && (rd_size >= size_ff);
   assign scan_last = ((32'(ptr_ff) + 32'd1) == 32'(count_ff));
   assign new_top   = base_ff + SUM_W'(size_ff);
   assign limit_cap = (SUM_W'(heap_limit_ff) < ADDR_SPAN) ? SUM_W'(heap_limit_ff) : ADDR_SPAN;
   assign rsp_load  = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      heap_top_in   = heap_top_ff;
      ptr_in        = ptr_ff;
      size_in       = size_ff;
      index_in      = index_ff;
      base_in       = base_ff;
      limit_in      = limit_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_index_in  = res_index_ff;
      res_reused_in = res_reused_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_reused_in = rsp_reused_ff;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff;
      mem_wdata     = {rd_size, rd_start, 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               size_in       = req_alloc_size;
               index_in      = req_block_index;
               ptr_in        = '0;
               base_in       = SUM_W'(heap_top_ff) + SUM_W'(header_bytes_ff);
               limit_in      = limit_cap;
               res_addr_in   = '0;
               res_reused_in = 1'b0;
               if (req_op == ffba_pkg::OP_FREE) begin
                  res_index_in = req_block_index;
                  mem_re       = 1'b1;
                  mem_raddr    = IDX_W'(req_block_index);
                  if (free_in_range) begin
                     state_in = S_FREE_CHK;
                  end else begin
                     res_status_in = ffba_pkg::ST_BADFREE;
                     state_in      = S_RESULT;
                  end
               end else begin
                  res_index_in = '0;
                  mem_re       = 1'b1;
                  mem_raddr    = '0;
                  if (req_alloc_size == '0) begin
                     res_status_in = ffba_pkg::ST_ZERO;
                     state_in      = S_RESULT;
                  end else if (count_ff == '0) begin
                     state_in = S_APPEND;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            end
         end

         S_FREE_CHK: begin
            if (rd_free) begin
               res_status_in = ffba_pkg::ST_BADFREE;
            end else begin
               res_status_in = ffba_pkg::ST_OK;
               mem_we        = 1'b1;
               mem_waddr     = IDX_W'(index_ff);
               mem_wdata     = {rd_size, rd_start, 1'b1};
            end
            state_in = S_RESULT;
         end

         S_SCAN: begin
            // prefetch the next entry while checking this one
            mem_re    = 1'b1;
            mem_raddr = ptr_ff + IDX_W'(1);
            if (scan_hit) begin
               mem_we        = 1'b1;
               mem_waddr     = ptr_ff;
               mem_wdata     = {rd_size, rd_start, 1'b0};
               res_status_in = ffba_pkg::ST_OK;
               res_addr_in   = SIZE_W'(rd_start);
               res_index_in  = ffba_pkg::INDEX_W'(ptr_ff);
               res_reused_in = 1'b1;
               state_in      = S_RESULT;
            end else if (scan_last) begin
               state_in = S_APPEND;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end

         S_APPEND: begin
            // heap check goes before the table check
            if (new_top > limit_ff) begin
               res_status_in = ffba_pkg::ST_HEAP;
            end else if (32'(count_ff) >= 32'(MAX_BLOCKS)) begin
               res_status_in = ffba_pkg::ST_TABLE;
            end else begin
               mem_we        = 1'b1;
               mem_waddr     = IDX_W'(count_ff);
               mem_wdata     = {size_ff, TOP_W'(base_ff), 1'b0};
               count_in      = count_ff + CNT_W'(1);
               heap_top_in   = TOP_W'(new_top);
               res_status_in = ffba_pkg::ST_OK;
               res_addr_in   = SIZE_W'(TOP_W'(base_ff));
               res_index_in  = ffba_pkg::INDEX_W'(count_ff);
            end
            state_in = S_RESULT;
         end

         S_RESULT: begin
            // hold until the output register frees up
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_index_in  = res_index_ff;
               rsp_reused_in = res_reused_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         heap_top_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         heap_top_ff  <= heap_top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      size_ff       <= size_in;
      index_ff      <= index_in;
      base_ff       <= base_in;
      limit_ff      <= limit_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_index_ff  <= res_index_in;
      res_reused_ff <= res_reused_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_reused_ff <= rsp_reused_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_payload_address = rsp_addr_ff;
   assign rsp_granted_index   = rsp_index_ff;
   assign rsp_reused          = rsp_reused_ff;

endmodule
`default_nettype wire

[sv/ffba_checker.sv]
`default_nettype none
module ffba_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [2:0]                   rsp_status,
   input wire logic [ffba_pkg::SIZE_W-1:0]  rsp_payload_address,
   input wire logic                         rsp_reused
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // one request in flight: stall right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   a_reuse_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reused |-> rsp_status == ffba_pkg::ST_OK)
      else $error("reuse flagged on failed request");

   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ffba_pkg::ST_OK |-> rsp_payload_address == '0)
      else $error("address given on failed request");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_status          (rsp_status),
   .rsp_payload_address (rsp_payload_address),
   .rsp_reused          (rsp_reused)
);
`default_nettype wire

[sim/tb_first_fit_block_allocator_unit.sv]
`default_nettype none
module tb_first_fit_block_allocator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIZE_W        = ffba_pkg::SIZE_W;
   localparam int INDEX_W       = ffba_pkg::INDEX_W;
   localparam int LIMIT_W       = ffba_pkg::LIMIT_W;
   localparam int HEADER_W      = ffba_pkg::HEADER_W;
   localparam int TABLE_DEPTH   = ffba_pkg::MAX_BLOCKS_DEFAULT;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 80;
   localparam int HOLD_CYCLES   = 400;
   localparam longint unsigned ADDR_SPAN = 64'd1 << ffba_pkg::ADDR_BITS_DEFAULT;

   typedef struct packed {
      logic [2:0]         status;
      logic [SIZE_W-1:0]  payload_address;
      logic [INDEX_W-1:0] granted_index;
      logic               reused;
   } alloc_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_op = ffba_pkg::OP_ALLOC;
   logic [SIZE_W-1:0]  req_alloc_size = '0;
   logic [INDEX_W-1:0] req_block_index = '0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_status;
   logic [SIZE_W-1:0]  rsp_payload_address;
   logic [INDEX_W-1:0] rsp_granted_index;
   logic               rsp_reused;

   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   // mirror of the block table, heap and registers
   logic [SIZE_W-1:0]   blk_size  [TABLE_DEPTH];
   logic [SIZE_W-1:0]   blk_start [TABLE_DEPTH];
   bit                  blk_free  [TABLE_DEPTH];
   int                  blk_count = 0;
   longint unsigned     heap_top = 0;
   logic [LIMIT_W-1:0]  heap_limit = ffba_pkg::HEAP_LIMIT_RESET;
   logic [HEADER_W-1:0] header_bytes = ffba_pkg::HEADER_BYTES_RESET;

   alloc_result_type    pending_results [$];
   int                  req_gap_pct = 0;
   int                  rsp_stall_pct = 0;
   int                  hold_requests = 0;
   int                  hold_served = 0;
   int                  hold_left = 0;
   int                  mismatch_count = 0;

   first_fit_block_allocator_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_alloc_size      (req_alloc_size),
      .req_block_index     (req_block_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_payload_address (rsp_payload_address),
      .rsp_granted_index   (rsp_granted_index),
      .rsp_reused          (rsp_reused),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Apply one request to the mirror and return the result it must produce.
   function automatic alloc_result_type heap_outcome(input logic op,
                                                     input logic [SIZE_W-1:0] size,
                                                     input logic [INDEX_W-1:0] idx);
      alloc_result_type res;
      longint unsigned  limit;
      longint unsigned  new_top;
      res = '0;
      if (op == ffba_pkg::OP_FREE) begin
         res.granted_index = idx;
         if (idx >= blk_count || blk_free[idx]) begin
            res.status = ffba_pkg::ST_BADFREE;
         end else begin
            blk_free[idx] = 1'b1;
            res.status = ffba_pkg::ST_OK;
         end
         return res;
      end
      if (size == '0) begin
         res.status = ffba_pkg::ST_ZERO;
         return res;
      end
      for (int i = 0; i < blk_count; i++) begin
         if (blk_free[i] && blk_size[i] >= size) begin
            blk_free[i] = 1'b0;
            res.status = ffba_pkg::ST_OK;
            res.payload_address = blk_start[i];
            res.granted_index = INDEX_W'(i);
            res.reused = 1'b1;
            return res;
         end
      end
      limit = (heap_limit > ADDR_SPAN) ? ADDR_SPAN : heap_limit;
      new_top = heap_top + header_bytes + size;
      if (new_top > limit) begin
         res.status = ffba_pkg::ST_HEAP;
      end else if (blk_count >= TABLE_DEPTH) begin
         res.status = ffba_pkg::ST_TABLE;
      end else begin
         blk_size[blk_count] = size;
         blk_start[blk_count] = SIZE_W'(heap_top + header_bytes);
         blk_free[blk_count] = 1'b0;
         res.status = ffba_pkg::ST_OK;
         res.payload_address = blk_start[blk_count];
         res.granted_index = INDEX_W'(blk_count);
         blk_count++;
         heap_top = new_top;
      end
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s mismatch: expected 0x%0h, got 0x%0h", what, want, got);
   endtask

   task automatic send_request(input logic op, input logic [SIZE_W-1:0] size,
                               input logic [INDEX_W-1:0] idx);
      if ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_gap_pct);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_alloc_size <= size;
      req_block_index <= idx;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(heap_outcome(op, size, idx));
   endtask

   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic sel, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {sel, 2'b00};
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write only with the block idle, then read the register back.
   task automatic csr_write(input logic sel, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] ignored;
      logic [31:0] want;
      drain_results(4);
      csr_access(1'b1, sel, value, ignored);
      if (sel == ffba_pkg::REG_HEAP_LIMIT) begin
         heap_limit = value[LIMIT_W-1:0];
         want = 32'(heap_limit);
      end else begin
         header_bytes = value[HEADER_W-1:0];
         want = 32'(header_bytes);
      end
      csr_access(1'b0, sel, '0, readback);
      if (readback !== want) flag_mismatch("register readback", want, readback);
   endtask

   task automatic test_directed_basics;
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      send_request(ffba_pkg::OP_FREE,  '0, '0);           // free on an empty table
      send_request(ffba_pkg::OP_FREE,  '1, '1);
      send_request(ffba_pkg::OP_ALLOC, '0, '1);           // zero size
      send_request(ffba_pkg::OP_ALLOC, 24'd1, '0);
      send_request(ffba_pkg::OP_ALLOC, '1, '0);           // largest size cannot fit
      send_request(ffba_pkg::OP_ALLOC, 24'd100, 6'd63);
      send_request(ffba_pkg::OP_ALLOC, 24'd40, '0);
      send_request(ffba_pkg::OP_FREE,  '1, 6'd1);
      send_request(ffba_pkg::OP_FREE,  '0, 6'd1);         // double free
      send_request(ffba_pkg::OP_FREE,  '0, 6'd3);         // past the last block
      send_request(ffba_pkg::OP_ALLOC, 24'd50, '0);       // reuse block 1 whole
      send_request(ffba_pkg::OP_FREE,  '0, 6'd0);
      send_request(ffba_pkg::OP_FREE,  '0, 6'd2);
      send_request(ffba_pkg::OP_ALLOC, 24'd41, '0);       // no free block big enough
      send_request(ffba_pkg::OP_ALLOC, 24'd40, '0);       // exact fit
      send_request(ffba_pkg::OP_ALLOC, 24'd1, '0);
      send_request(ffba_pkg::OP_FREE,  '0, 6'd63);
      send_request(ffba_pkg::OP_ALLOC, 24'hFFFFFE, '0);
   endtask

   task automatic test_register_extremes;
      longint unsigned exact;
      csr_write(ffba_pkg::REG_HEADER_BYTES, 32'd0);
      send_request(ffba_pkg::OP_ALLOC, 24'd7000, '0);
      csr_write(ffba_pkg::REG_HEADER_BYTES, 32'd127);
      send_request(ffba_pkg::OP_ALLOC, 24'd7001, '0);
      csr_write(ffba_pkg::REG_HEADER_BYTES, 32'd64);
      send_request(ffba_pkg::OP_ALLOC, 24'd7002, '0);
      csr_write(ffba_pkg::REG_HEAP_LIMIT, 32'd0);
      send_request(ffba_pkg::OP_ALLOC, 24'd9000, '0);     // no room at all
      send_request(ffba_pkg::OP_FREE, '0, INDEX_W'(blk_count - 1));
      send_request(ffba_pkg::OP_ALLOC, 24'd6000, '0);     // reuse still works with no room
      exact = heap_top + header_bytes + 9000;
      csr_write(ffba_pkg::REG_HEAP_LIMIT, 32'(exact - 1));
      send_request(ffba_pkg::OP_ALLOC, 24'd9000, '0);
      csr_write(ffba_pkg::REG_HEAP_LIMIT, 32'(exact));
      send_request(ffba_pkg::OP_ALLOC, 24'd9000, '0);     // lands exactly on the limit
      send_request(ffba_pkg::OP_ALLOC, 24'd9001, '0);
      csr_write(ffba_pkg::REG_HEAP_LIMIT, 32'h1FF_FFFF);  // capped at the address span
      send_request(ffba_pkg::OP_ALLOC, '1, '0);
   endtask

   task automatic test_random_traffic(input int items, input int gap_pct, input int stall_pct,
                                      input logic [31:0] limit, input logic [31:0] header);
      logic               op;
      logic [SIZE_W-1:0]  size;
      logic [INDEX_W-1:0] idx;
      int                 roll;
      csr_write(ffba_pkg::REG_HEAP_LIMIT, limit);
      csr_write(ffba_pkg::REG_HEADER_BYTES, header);
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      repeat (items) begin
         roll = $urandom_range(99);
         idx = INDEX_W'($urandom);
         size = SIZE_W'($urandom);
         if (roll < 45) begin
            op = ffba_pkg::OP_FREE;
            if (blk_count > 0 && $urandom_range(4) != 0)
               idx = INDEX_W'($urandom_range(blk_count - 1));
         end else begin
            op = ffba_pkg::OP_ALLOC;
            roll = $urandom_range(99);
            if (roll < 4)
               size = '0;
            else if (roll < 12)
               size = SIZE_W'($urandom);
            else if (roll < 20)
               size = {1'b1, 23'($urandom)};
            else if (roll < 50 && blk_count > 0)
               size = blk_size[$urandom_range(blk_count - 1)] - SIZE_W'($urandom_range(3));
            else
               size = SIZE_W'($urandom_range(1024, 1));
         end
         send_request(op, size, idx);
      end
   endtask

   // Fill every table slot, then check that heap room is judged before table room.
   task automatic test_growth_order;
      int              first_free;
      longint unsigned room;
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      csr_write(ffba_pkg::REG_HEAP_LIMIT, 32'h1FF_FFFF);
      csr_write(ffba_pkg::REG_HEADER_BYTES, 32'd0);
      for (int guard = 0; guard < 3 * TABLE_DEPTH; guard++) begin
         first_free = -1;
         for (int i = blk_count - 1; i >= 0; i--)
            if (blk_free[i]) first_free = i;
         if (first_free < 0 && blk_count >= TABLE_DEPTH) break;
         send_request(ffba_pkg::OP_ALLOC,
                      (first_free < 0) ? SIZE_W'(1) : blk_size[first_free], '0);
      end
      send_request(ffba_pkg::OP_ALLOC, '1, '0);
      room = ADDR_SPAN - heap_top;
      if (room > 0)
         send_request(ffba_pkg::OP_ALLOC, (room > 24'hFFFFFF) ? '1 : SIZE_W'(room), '0);
      csr_write(ffba_pkg::REG_HEADER_BYTES, 32'd127);
      if (room > 128 && room < ADDR_SPAN) begin
         send_request(ffba_pkg::OP_ALLOC, SIZE_W'(room - 126), '0);
         send_request(ffba_pkg::OP_ALLOC, SIZE_W'(room - 127), '0);
      end
   endtask

   // Hold the result side off while requests keep coming, so the block backs up.
   task automatic test_backpressure;
      drain_results(4);
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      hold_requests++;
      for (int i = 0; i < 12; i++)
         send_request(i[0] ? ffba_pkg::OP_FREE : ffba_pkg::OP_ALLOC,
                      SIZE_W'($urandom_range(64, 1)),
                      INDEX_W'($urandom_range(TABLE_DEPTH - 1)));
      drain_results(4);
   endtask

   always @(posedge clock) begin : rsp_check
      alloc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("unrequested result, status", '0, 32'(rsp_status));
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               flag_mismatch("status", 32'(want.status), 32'(rsp_status));
            if (rsp_payload_address !== want.payload_address)
               flag_mismatch("payload_address", 32'(want.payload_address),
                             32'(rsp_payload_address));
            if (rsp_granted_index !== want.granted_index)
               flag_mismatch("granted_index", 32'(want.granted_index),
                             32'(rsp_granted_index));
            if (rsp_reused !== want.reused)
               flag_mismatch("reused", 32'(want.reused), 32'(rsp_reused));
         end
      end
   end

   always @(posedge clock) begin : rsp_stall_drive
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("first_fit_block_allocator_unit verification failed");
      $finish;
   end

   initial begin : run
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_register_extremes();
      test_random_traffic(600, 30, 79, 32'h40_0000, 32'd24);
      test_growth_order();
      test_random_traffic(550, 79, 30, 32'h1FF_FFFF, 32'd64);
      test_backpressure();
      test_random_traffic(550, 0, 0, 32'(ffba_pkg::HEAP_LIMIT_RESET), 32'd127);
      drain_results(SETTLE_CYCLES);
      if (mismatch_count == 0)
         $display("first_fit_block_allocator_unit verification clean");
      else
         $display("first_fit_block_allocator_unit verification failed");
      $finish;
   end

endmodule
`default_nettype wire
